// ===== rtl/acdf_pkg.sv =====
package acdf_pkg;

  // Fixed byte values of the exchange.
  localparam logic [7:0]  ACK_ZERO   = 8'h00;
  localparam logic [7:0]  ACK_ONES   = 8'hFF;
  localparam logic [7:0]  HDR_BYTE   = 8'h80;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] MAX_LEN_RST = 16'd260;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_BODY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_LEN = 2'd1;

  // Final status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ACK_ERR  = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_CRC_BAD  = 3'd4
  } status_e;

  // Result kinds.
  localparam logic KIND_BODY  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // One result item as it travels from the receiver to the output register.
  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [15:0] byte_index;
    logic [2:0]  status;
    logic [15:0] body_length;
    logic        last;
  } acdf_res_t;

  // One byte of CRC-16 CCITT (poly 0x1021, MSB first), table-free form.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'b0000, x[7:4]};
    crc_step = {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
               ^ {8'h00, x};
  endfunction

endpackage

// ===== rtl/acdf_fsm.sv =====
module acdf_fsm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [acdf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             step_i,
  input  logic [7:0]                       byte_i,
  output logic                             res_valid_o,
  output acdf_pkg::acdf_res_t              res_o
);

  typedef enum logic [6:0] {
    PH_ACK    = 7'b0000001,
    PH_HDR    = 7'b0000010,
    PH_LEN_LO = 7'b0000100,
    PH_LEN_HI = 7'b0001000,
    PH_BODY   = 7'b0010000,
    PH_CRC_LO = 7'b0100000,
    PH_CRC_HI = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        expect_body_q;
  logic [15:0] max_len_q;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] seen_q, seen_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] len_word;
  logic [15:0] seen_inc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_body_q <= 1'b1;
      max_len_q     <= acdf_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == acdf_pkg::CFG_EXPECT_BODY) begin
        expect_body_q <= cfg_data_i[0];
      end else if (cfg_idx_i == acdf_pkg::CFG_MAX_BODY_LEN) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  assign len_word = {byte_i, hold_q};
  assign seen_inc = seen_q + 16'd1;

  // Per-byte state update and result forming.
  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    seen_d      = seen_q;
    crc_d       = crc_q;
    hold_d      = hold_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = acdf_pkg::KIND_FINAL;
    res_o.last  = 1'b1;
    case (phase_q)
      PH_HDR: begin
        if (byte_i != acdf_pkg::HDR_BYTE) begin
          res_valid_o  = 1'b1;
          res_o.status = acdf_pkg::ST_BAD_HDR;
          phase_d      = PH_ACK;
        end else begin
          phase_d = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        hold_d  = byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len_d = len_word;
        if (len_word > max_len_q) begin
          res_valid_o       = 1'b1;
          res_o.status      = acdf_pkg::ST_TOO_LONG;
          res_o.body_length = len_word;
          phase_d           = PH_ACK;
        end else begin
          seen_d  = '0;
          crc_d   = acdf_pkg::CRC_INIT;
          phase_d = (len_word == 16'd0) ? PH_CRC_LO : PH_BODY;
        end
      end
      PH_BODY: begin
        res_valid_o      = 1'b1;
        res_o.kind       = acdf_pkg::KIND_BODY;
        res_o.last       = 1'b0;
        res_o.body_byte  = byte_i;
        res_o.byte_index = seen_q;
        crc_d            = acdf_pkg::crc_step(crc_q, byte_i);
        seen_d           = seen_inc;
        if (seen_inc >= frame_len_q) begin
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        hold_d  = byte_i;
        phase_d = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res_valid_o       = 1'b1;
        res_o.status      = (len_word == crc_q) ? acdf_pkg::ST_OK : acdf_pkg::ST_CRC_BAD;
        res_o.body_length = frame_len_q;
        phase_d           = PH_ACK;
      end
      default: begin
        // Waiting for the acknowledge byte; stray codes land here as well.
        phase_d = PH_ACK;
        if (byte_i != acdf_pkg::ACK_ZERO && byte_i != acdf_pkg::ACK_ONES) begin
          res_valid_o  = 1'b1;
          res_o.status = acdf_pkg::ST_ACK_ERR;
        end else begin
          frame_len_d = '0;
          seen_d      = '0;
          crc_d       = acdf_pkg::CRC_INIT;
          if (!expect_body_q) begin
            res_valid_o  = 1'b1;
            res_o.status = acdf_pkg::ST_OK;
          end else begin
            phase_d = PH_HDR;
          end
        end
      end
    endcase
  end

  // Receiver state advances only when a byte is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ACK;
      frame_len_q <= '0;
      seen_q      <= '0;
      crc_q       <= acdf_pkg::CRC_INIT;
      hold_q      <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      seen_q      <= seen_d;
      crc_q       <= crc_d;
      hold_q      <= hold_d;
    end
  end

  // A body byte can only be emitted with an index below the declared length.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_BODY) |-> (seen_q < frame_len_q))
    else $error("body byte index reached the declared length");

  // Every final status sends the receiver back to waiting for an ack.
  a_final_to_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && res_o.last) |=> (phase_q == PH_ACK))
    else $error("final status did not return to ack phase");

endmodule

// ===== rtl/ack_and_crc_response_deframer_top.sv =====
// Path: a byte waits in the input register until it is processed; its result, if any, is
// captured in the result register at that edge. Throughput: one byte per cycle while the
// result register is free or being read; the single-step CRC update sets no limit.
// Reset: rst_ni is asynchronous and active low; the receiver waits for an ack,
// expect_body resets to 1 and max_body_len to 260.
module ack_and_crc_response_deframer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [acdf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           result_kind_o,
  output logic [7:0]                     body_byte_o,
  output logic [15:0]                    byte_index_o,
  output logic [2:0]                     status_o,
  output logic [15:0]                    body_length_o,
  output logic                           last_o
);

  logic                in_vld_q;
  logic [7:0]          in_byte_q;
  logic                adv;
  logic                res_valid;
  acdf_pkg::acdf_res_t res;
  logic                out_vld_q, out_vld_d;
  acdf_pkg::acdf_res_t out_q;

  // The held byte is processed whenever the result register is free or emptying.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  acdf_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (adv),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = res_valid;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_kind_o = out_q.kind;
  assign body_byte_o   = out_q.body_byte;
  assign byte_index_o  = out_q.byte_index;
  assign status_o      = out_q.status;
  assign body_length_o = out_q.body_length;
  assign last_o        = out_q.last;

  // The input side stalls only behind a held byte and a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  // A final status is always flagged last, a body byte never.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.last == out_q.kind))
    else $error("last flag disagrees with result kind");

  // A body byte result carries no status or length.
  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == acdf_pkg::KIND_BODY)
      |-> (out_q.status == acdf_pkg::ST_OK && out_q.body_length == 16'd0))
    else $error("body byte result has status or length set");

endmodule
